FILE: hdl/gofv_pkg.sv
package gofv_pkg;

  localparam int unsigned NumPoints = 8;
  localparam int unsigned Q14Shift  = 14;
  localparam int unsigned Q14Half   = 8192;

  localparam logic [1:0] SubFirst  = 2'd0;
  localparam logic [1:0] SubSecond = 2'd1;
  localparam logic [1:0] SubCenter = 2'd2;

  localparam logic [2:0] LastTri = 3'(NumPoints - 1);

  typedef struct packed {
    logic [30:0]        half_width;
    logic [30:0]        half_height;
    logic [30:0]        cut_x;
    logic [30:0]        cut_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [15:0] cosine;
    logic signed [15:0] sine;
    logic               rotate_enable;
    logic [31:0]        rgba;
  } item_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [31:0]        vertex_rgba;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic signed [47:0] xc;
    logic signed [47:0] ys;
    logic signed [47:0] xs;
    logic signed [47:0] yc;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               rot;
    logic               center;
    logic               last;
    logic [31:0]        rgba;
  } stage_t;

endpackage

FILE: hdl/gofv_rotate.sv
module gofv_rotate (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              issue_i,
  input  gofv_pkg::item_t   item_i,
  input  logic [2:0]        tri_i,
  input  logic [1:0]        sub_i,
  output gofv_pkg::stage_t  stage_o,
  output logic              stage_valid_o
);
  import gofv_pkg::*;

  logic signed [31:0] w, h, a, b;
  logic signed [31:0] x_pt, y_pt;
  logic [2:0]         pt_idx;
  stage_t             stage_d, stage_q;
  logic               valid_q;

  assign w = signed'({1'b0, item_i.half_width});
  assign h = signed'({1'b0, item_i.half_height});
  assign a = signed'({1'b0, item_i.cut_x});
  assign b = signed'({1'b0, item_i.cut_y});

  // next point wraps back to the first one through the 3 bit add
  assign pt_idx = (sub_i == SubFirst) ? tri_i : tri_i + 3'd1;

  always_comb begin
    case (pt_idx)
      3'd0: begin x_pt = a - w; y_pt = -h;    end
      3'd1: begin x_pt = w - a; y_pt = -h;    end
      3'd2: begin x_pt = w;     y_pt = b - h; end
      3'd3: begin x_pt = w;     y_pt = h - b; end
      3'd4: begin x_pt = w - a; y_pt = h;     end
      3'd5: begin x_pt = a - w; y_pt = h;     end
      3'd6: begin x_pt = -w;    y_pt = h - b; end
      default: begin x_pt = -w; y_pt = b - h; end
    endcase
  end

  always_comb begin
    stage_d.xc     = 48'(x_pt) * 48'(item_i.cosine);
    stage_d.ys     = 48'(y_pt) * 48'(item_i.sine);
    stage_d.xs     = 48'(x_pt) * 48'(item_i.sine);
    stage_d.yc     = 48'(y_pt) * 48'(item_i.cosine);
    stage_d.px     = x_pt;
    stage_d.py     = y_pt;
    stage_d.cx     = item_i.center_x;
    stage_d.cy     = item_i.center_y;
    stage_d.rot    = item_i.rotate_enable;
    stage_d.center = (sub_i == SubCenter);
    stage_d.last   = (sub_i == SubCenter) && (tri_i == LastTri);
    stage_d.rgba   = item_i.rgba;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_o       = stage_q;
  assign stage_valid_o = valid_q;

endmodule

FILE: hdl/gofv_finish.sv
module gofv_finish (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gofv_pkg::stage_t  stage_i,
  input  logic              stage_valid_i,
  output gofv_pkg::vertex_t vertex_o,
  output logic              vertex_valid_o
);
  import gofv_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi, lo;
    hi = 36'sh07FFFFFFF;
    lo = -36'sh080000000;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  logic signed [48:0] sum_x, sum_y;
  logic signed [34:0] rnd_x, rnd_y;
  logic signed [35:0] off_x, off_y;
  vertex_t            vertex_d, vertex_q;
  logic               valid_q;

  assign sum_x = 49'(stage_i.xc) - 49'(stage_i.ys) + 49'(Q14Half);
  assign sum_y = 49'(stage_i.xs) + 49'(stage_i.yc) + 49'(Q14Half);
  assign rnd_x = sum_x[48:Q14Shift];
  assign rnd_y = sum_y[48:Q14Shift];

  always_comb begin
    if (stage_i.rot) begin
      off_x = 36'(rnd_x) + 36'(stage_i.cx);
      off_y = 36'(rnd_y) + 36'(stage_i.cy);
    end else begin
      off_x = 36'(stage_i.px) + 36'(stage_i.cx);
      off_y = 36'(stage_i.py) + 36'(stage_i.cy);
    end
    if (stage_i.center) begin
      vertex_d.vertex_x    = stage_i.cx;
      vertex_d.vertex_y    = stage_i.cy;
      vertex_d.vertex_rgba = stage_i.rgba;
    end else begin
      vertex_d.vertex_x    = sat32(off_x);
      vertex_d.vertex_y    = sat32(off_y);
      vertex_d.vertex_rgba = {stage_i.rgba[31:8], 8'h00};
    end
    vertex_d.last = stage_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vertex_q <= vertex_d;
  end

  assign vertex_o       = vertex_q;
  assign vertex_valid_o = valid_q;

endmodule

FILE: hdl/glow_octagon_fan_vertices_core.sv
// start transfer sets active_q, then vertices pass the rotate and finish stages
// throughput: 24 vertices per item, one per cycle, set by the vertex counter
// a new item is taken during the last vertex issue, so items run back to back
// reset clears the counter and the valid flags, no result survives reset
// the receiver cannot stall, each vertex is shown for exactly one cycle
module glow_octagon_fan_vertices_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gofv_pkg::item_t   item_i,
  output gofv_pkg::vertex_t vertex_o,
  output logic              vertex_valid_o
);
  import gofv_pkg::*;

  item_t            item_q;
  logic             active_q;
  logic [2:0]       tri_q;
  logic [1:0]       sub_q;
  logic             last_issue;
  logic             accept;
  stage_t           stage;
  logic             stage_valid;

  assign last_issue = active_q && (tri_q == LastTri) && (sub_q == SubCenter);
  assign busy       = active_q && !last_issue;
  assign accept     = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tri_q    <= 3'd0;
      sub_q    <= SubFirst;
    end else if (accept) begin
      active_q <= 1'b1;
      tri_q    <= 3'd0;
      sub_q    <= SubFirst;
    end else if (last_issue) begin
      active_q <= 1'b0;
    end else if (active_q) begin
      if (sub_q == SubCenter) begin
        sub_q <= SubFirst;
        tri_q <= tri_q + 3'd1;
      end else begin
        sub_q <= (sub_q == SubFirst) ? SubSecond : SubCenter;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  gofv_rotate u_rotate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (active_q),
    .item_i        (item_q),
    .tri_i         (tri_q),
    .sub_i         (sub_q),
    .stage_o       (stage),
    .stage_valid_o (stage_valid)
  );

  gofv_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_i        (stage),
    .stage_valid_i  (stage_valid),
    .vertex_o       (vertex_o),
    .vertex_valid_o (vertex_valid_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after start transfer");

  a_accept_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 vertex_valid_o)
    else $error("first vertex missing three cycles after start transfer");

  a_last_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vertex_valid_o && vertex_o.last) |-> $past(vertex_valid_o))
    else $error("last vertex without preceding vertex");

  a_issue_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_issue |-> ##2 (vertex_valid_o && vertex_o.last))
    else $error("last issued vertex not flagged last");

endmodule

FILE: tb/sv/tb_glow_octagon_fan_vertices_core.sv
module tb_glow_octagon_fan_vertices_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gofv_pkg::*;

  localparam int     CycleLimit = 400000;
  localparam int     SettleCycles = 8;
  localparam int     FracBits = 14;
  localparam longint RoundHalf = 8192;
  localparam longint MaxQ16 = 64'sd2147483647;
  localparam longint MinQ16 = -64'sd2147483648;
  localparam logic [30:0] MaxSize = 31'h7FFF_FFFF;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  vertex_t vertex_o;
  logic    vertex_valid_o;

  vertex_t fan_vertex_q[$];
  vertex_t want_vertex;
  int      mismatch_count = 0;
  int      cycle_count = 0;

  glow_octagon_fan_vertices_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .vertex_o       (vertex_o),
    .vertex_valid_o (vertex_valid_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] clamp_q16(longint v);
    if (v > MaxQ16) begin
      return 32'h7FFF_FFFF;
    end
    if (v < MinQ16) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // expected fan of 24 vertices for one item
  function automatic void push_fan_vertices(item_t it);
    longint      w, h, a, b, cx, cy, c, s, x, y;
    longint      lx[NumPoints];
    longint      ly[NumPoints];
    logic [31:0] ox[NumPoints];
    logic [31:0] oy[NumPoints];
    logic [31:0] clear;
    vertex_t     v;
    int          j;
    w  = longint'(it.half_width);
    h  = longint'(it.half_height);
    a  = longint'(it.cut_x);
    b  = longint'(it.cut_y);
    cx = longint'($signed(it.center_x));
    cy = longint'($signed(it.center_y));
    c  = longint'($signed(it.cosine));
    s  = longint'($signed(it.sine));
    clear = it.rgba & 32'hFFFF_FF00;
    lx[0] = -w + a; ly[0] = -h;
    lx[1] = w - a;  ly[1] = -h;
    lx[2] = w;      ly[2] = -h + b;
    lx[3] = w;      ly[3] = h - b;
    lx[4] = w - a;  ly[4] = h;
    lx[5] = -w + a; ly[5] = h;
    lx[6] = -w;     ly[6] = h - b;
    lx[7] = -w;     ly[7] = -h + b;
    for (int i = 0; i < NumPoints; i++) begin
      x = lx[i];
      y = ly[i];
      if (it.rotate_enable) begin
        // round half up: floor of (sum + half) / 2^14
        x = (lx[i] * c - ly[i] * s + RoundHalf) >>> FracBits;
        y = (lx[i] * s + ly[i] * c + RoundHalf) >>> FracBits;
      end
      ox[i] = clamp_q16(x + cx);
      oy[i] = clamp_q16(y + cy);
    end
    for (int i = 0; i < NumPoints; i++) begin
      j = (i + 1) % NumPoints;
      v.vertex_x = ox[i];
      v.vertex_y = oy[i];
      v.vertex_rgba = clear;
      v.last = 1'b0;
      fan_vertex_q.push_back(v);
      v.vertex_x = ox[j];
      v.vertex_y = oy[j];
      fan_vertex_q.push_back(v);
      v.vertex_x = it.center_x;
      v.vertex_y = it.center_y;
      v.vertex_rgba = it.rgba;
      v.last = (i == NumPoints - 1);
      fan_vertex_q.push_back(v);
    end
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && vertex_valid_o) begin
      if (fan_vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex, expected none, actual %h", $time, vertex_o);
        mismatch_count++;
      end else begin
        want_vertex = fan_vertex_q.pop_front();
        compare_field("vertex_x", want_vertex.vertex_x, vertex_o.vertex_x);
        compare_field("vertex_y", want_vertex.vertex_y, vertex_o.vertex_y);
        compare_field("vertex_rgba", want_vertex.vertex_rgba, vertex_o.vertex_rgba);
        compare_field("last", 32'(want_vertex.last), 32'(vertex_o.last));
      end
    end
  end

  // start stays high after the transfer so a following item can go back to back
  task automatic send_item(item_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    push_fan_vertices(it);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (fan_vertex_q.size() != 0);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(12, 60);
  endfunction

  function automatic item_t make_item(logic [30:0] w, logic [30:0] h, logic [30:0] a,
                                      logic [30:0] b, logic [31:0] cx, logic [31:0] cy,
                                      logic [15:0] c, logic [15:0] s, logic rot,
                                      logic [31:0] rgba);
    item_t it;
    it.half_width = w;
    it.half_height = h;
    it.cut_x = a;
    it.cut_y = b;
    it.center_x = cx;
    it.center_y = cy;
    it.cosine = c;
    it.sine = s;
    it.rotate_enable = rot;
    it.rgba = rgba;
    return it;
  endfunction

  function automatic logic [30:0] rand_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return 31'($urandom);
    end else if (sel == 1) begin
      return $urandom_range(0, 1) ? MaxSize : 31'd0;
    end
    return 31'($urandom_range(0, 32'h00FF_FFFF));
  endfunction

  function automatic logic [30:0] rand_cut(logic [30:0] size);
    if ($urandom_range(0, 4) == 0) begin
      return rand_size();
    end
    return 31'($urandom_range(0, 32'(size)));
  endfunction

  function automatic logic [31:0] rand_center();
    if ($urandom_range(0, 9) < 7) begin
      return 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
    end
    return $urandom;
  endfunction

  function automatic logic [15:0] rand_trig();
    if ($urandom_range(0, 4) == 0) begin
      return 16'($urandom);
    end
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.half_width = rand_size();
    it.half_height = rand_size();
    it.cut_x = rand_cut(it.half_width);
    it.cut_y = rand_cut(it.half_height);
    it.center_x = rand_center();
    it.center_y = rand_center();
    it.cosine = rand_trig();
    it.sine = rand_trig();
    it.rotate_enable = 1'($urandom_range(0, 1));
    it.rgba = $urandom;
    return it;
  endfunction

  task automatic test_field_extremes();
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 32'h0000_0000));
    idle_gap(pick_gap());
    send_item(make_item(MaxSize, MaxSize, MaxSize, MaxSize, 0, 0, 0, 0, 1'b0,
                        32'hFFFF_FFFF));
    idle_gap(pick_gap());
    // positive and negative saturation
    send_item(make_item(MaxSize, MaxSize, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1'b0,
                        32'h1234_56FF));
    idle_gap(pick_gap());
    send_item(make_item(MaxSize, MaxSize, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 1'b0,
                        32'hA5A5_A5A5));
    idle_gap(pick_gap());
    // cut larger than the half size folds the outline
    send_item(make_item(31'h0001_0000, 31'h0002_0000, 31'h0003_0000, 31'h0005_0000,
                        32'h1234_5678, 32'hEDCB_A988, 0, 0, 1'b0, 32'h00FF_0080));
    idle_gap(pick_gap());
    send_item(make_item(31'h0004_8000, 31'h0002_4000, 31'h0000_8000, 31'h0001_0000,
                        32'hFFF0_0000, 32'h0010_0000, 16'h4000, 0, 1'b0, 32'h8040_2010));
    idle_gap(pick_gap());
  endtask

  task automatic test_rotation_cases();
    // identity, quarter turns and half turn
    send_item(make_item(31'h0003_0000, 31'h0002_0000, 31'h0000_8000, 31'h0000_4000,
                        32'h0001_0000, 32'hFFFF_0000, 16'h4000, 16'h0000, 1'b1, 32'h1122_3344));
    idle_gap(pick_gap());
    send_item(make_item(31'h0003_0000, 31'h0002_0000, 31'h0000_8000, 31'h0000_4000,
                        0, 0, 16'h0000, 16'h4000, 1'b1, 32'h5566_7788));
    idle_gap(pick_gap());
    send_item(make_item(31'h0003_0000, 31'h0002_0000, 31'h0000_8000, 31'h0000_4000,
                        0, 0, 16'hC000, 16'h0000, 1'b1, 32'h99AA_BBCC));
    idle_gap(pick_gap());
    send_item(make_item(31'h0003_0000, 31'h0002_0000, 31'h0000_8000, 31'h0000_4000,
                        0, 0, 16'h0000, 16'hC000, 1'b1, 32'hDDEE_FF00));
    idle_gap(pick_gap());
    // exact halves round toward plus infinity
    send_item(make_item(1, 1, 0, 0, 0, 0, 16'h2000, 16'h2000, 1'b1, 32'h0102_0304));
    idle_gap(pick_gap());
    send_item(make_item(3, 1, 1, 0, 0, 0, 16'hE000, 16'h2000, 1'b1, 32'h0506_0708));
    idle_gap(pick_gap());
    // out of range trig values, not normalized
    send_item(make_item(MaxSize, MaxSize, 0, 0, 32'h7FFF_FFFF, 32'h0000_0000,
                        16'h7FFF, 16'h8000, 1'b1, 32'hFFFF_FF00));
    idle_gap(pick_gap());
    send_item(make_item(MaxSize, MaxSize, MaxSize, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                        16'h8000, 16'h7FFF, 1'b1, 32'h0000_00FF));
    idle_gap(pick_gap());
    // trig values ignored when rotation is off
    send_item(make_item(31'h0010_0000, 31'h0008_0000, 31'h0002_0000, 31'h0001_0000,
                        32'h0000_1234, 32'h0000_5678, 16'h1234, 16'hFEDC, 1'b0, 32'hCAFE_F00D));
    idle_gap(pick_gap());
    send_item(make_item(31'h0010_0000, 31'h0008_0000, 31'h0002_0000, 31'h0001_0000,
                        32'h0000_1234, 32'h0000_5678, 16'd11585, 16'd11585, 1'b1,
                        32'hBEEF_1234));
    idle_gap(pick_gap());
  endtask

  task automatic test_random_fans(int count);
    for (int n = 0; n < count; n++) begin
      send_item(rand_item());
      idle_gap(pick_gap());
    end
  endtask

  task automatic test_back_to_back(int count);
    for (int n = 0; n < count; n++) begin
      send_item(rand_item());
    end
  endtask

  task automatic test_drain_pause(int count);
    for (int n = 0; n < count; n++) begin
      send_item(rand_item());
    end
    wait_drained();
    for (int n = 0; n < count; n++) begin
      send_item(rand_item());
      idle_gap(pick_gap());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_rotation_cases();
    test_random_fans(150);
    test_back_to_back(30);
    test_drain_pause(10);
    test_random_fans(140);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && fan_vertex_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/gofv_pkg.sv
hdl/gofv_rotate.sv
hdl/gofv_finish.sv
hdl/glow_octagon_fan_vertices_core.sv
tb/sv/tb_glow_octagon_fan_vertices_core.sv
